FILE: src/tdut_pkg.sv
`timescale 1ns / 1ps
// Package for the tick driven UART transceiver: word types and shared constants.
// Depends on nothing; the top level imports it.
package tdut_pkg;

    localparam int TX_QUEUE_DEPTH_DEFAULT = 16;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_QUEUE = 1'b1;

    localparam int PARITY_MODE_W = 2;
    localparam logic [PARITY_MODE_W-1:0] PARITY_NONE = 2'd0;
    localparam logic [PARITY_MODE_W-1:0] PARITY_ODD  = 2'd1;

    localparam int APB_ADDR_W = 3;
    localparam logic REG_IDX_PARITY_MODE = 1'b0;

    typedef struct packed {
        logic       action;
        logic       rx_level;
        logic [7:0] tx_byte;
    } in_word_t;

    typedef struct packed {
        logic       tx_level;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_parity_error;
        logic       tx_busy;
        logic       tx_accepted;
    } out_word_t;

endpackage

FILE: src/tdut_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface that carries one word of a given type.
// Depends on no other file; the word type is set by a parameter.
interface tdut_chan_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/tick_driven_uart_transceiver_unit.sv
`timescale 1ns / 1ps
// Top level of the tick driven UART transceiver: receiver, transmitter and queue memory.
// Depends on tdut_pkg and tdut_chan_if.
//
//  Channel   Direction  Handshake       Word
//  item      in         valid/ready     action, rx_level, tx_byte
//  result    out        valid/ready     tx_level, rx_byte, rx_valid, rx_parity_error,
//                                       tx_busy, tx_accepted
//  apb       in         psel/penable    parity_mode at byte address 0
//
// One word is taken every clock unless the result stalls; its result word goes into the
// output register. The queue memory is read at the next read pointer every cycle, so
// the byte being sent is ready in its read register, with a same-cycle write forwarded.
// Reset clears all control state; queue entries hold nothing until written.
// A stalled result holds the output register, and the input is taken only while it
// is empty or being emptied in that cycle.
module tick_driven_uart_transceiver_unit
    import tdut_pkg::*;
#(
    parameter int TX_QUEUE_DEPTH = TX_QUEUE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tdut_chan_if.sink             item,
    tdut_chan_if.source           result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int PTR_W = (TX_QUEUE_DEPTH > 1) ? $clog2(TX_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TX_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TX_QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TX_QUEUE_DEPTH);

    typedef enum logic [2:0] {
        RX_WAIT, RX_IDLE, RX_DATA, RX_PAR, RX_STOP
    } rx_mode_t;

    typedef enum logic [2:0] {
        TX_OFF, TX_START, TX_DATA, TX_PAR, TX_STOP
    } tx_mode_t;

    logic [PARITY_MODE_W-1:0] parity_mode_reg;
    logic                     tick_phase_reg, tick_phase_next;
    rx_mode_t                 rx_mode_reg, rx_mode_next;
    logic [7:0]               rx_shift_reg, rx_shift_next;
    logic [3:0]               rx_bit_count_reg, rx_bit_count_next;
    logic                     rx_parity_acc_reg, rx_parity_acc_next;
    logic                     rx_prev_level_reg, rx_prev_level_next;
    tx_mode_t                 tx_mode_reg, tx_mode_next;
    logic [3:0]               tx_bit_count_reg, tx_bit_count_next;
    logic                     tx_parity_acc_reg, tx_parity_acc_next;
    logic                     tx_line_reg, tx_line_next;
    logic [PTR_W-1:0]         tx_read_ptr_reg, tx_read_ptr_next;
    logic [PTR_W-1:0]         tx_write_ptr_reg, tx_write_ptr_next;
    logic [CNT_W-1:0]         tx_queue_count_reg, tx_queue_count_next;
    logic                     out_valid_reg;
    out_word_t                out_word_reg, out_word_next;

    logic [7:0]               tx_queue_mem [TX_QUEUE_DEPTH];
    logic [7:0]               tx_head_reg;
    logic                     mem_we;

    logic                     in_accept;
    logic                     cfg_write;
    logic                     tx_bit;
    logic                     rx_bad;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[APB_ADDR_W-1] == REG_IDX_PARITY_MODE)
                       ? {{(32 - PARITY_MODE_W){1'b0}}, parity_mode_reg} : 32'd0;

    assign item.ready   = !out_valid_reg || result.ready;
    assign in_accept    = item.valid && item.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    assign tx_bit = tx_head_reg[tx_bit_count_reg[2:0]];

    always_comb
    begin
        tick_phase_next     = tick_phase_reg;
        rx_mode_next        = rx_mode_reg;
        rx_shift_next       = rx_shift_reg;
        rx_bit_count_next   = rx_bit_count_reg;
        rx_parity_acc_next  = rx_parity_acc_reg;
        rx_prev_level_next  = rx_prev_level_reg;
        tx_mode_next        = tx_mode_reg;
        tx_bit_count_next   = tx_bit_count_reg;
        tx_parity_acc_next  = tx_parity_acc_reg;
        tx_line_next        = tx_line_reg;
        tx_read_ptr_next    = tx_read_ptr_reg;
        tx_write_ptr_next   = tx_write_ptr_reg;
        tx_queue_count_next = tx_queue_count_reg;
        mem_we              = 1'b0;
        rx_bad              = 1'b0;
        out_word_next       = '0;

        if (in_accept)
        begin
            if (item.data.action == ACT_QUEUE)
            begin
                if (tx_queue_count_reg < CNT_FULL)
                begin
                    mem_we                    = 1'b1;
                    tx_write_ptr_next         = (tx_write_ptr_reg == PTR_LAST)
                                                ? '0 : tx_write_ptr_reg + 1'b1;
                    tx_queue_count_next       = tx_queue_count_reg + 1'b1;
                    out_word_next.tx_accepted = 1'b1;
                end
            end
            else
            begin
                tick_phase_next = !tick_phase_reg;
                if (!tick_phase_reg)
                begin
                    unique case (rx_mode_reg)
                        RX_IDLE:
                        begin
                            rx_shift_next      = '0;
                            rx_bit_count_next  = '0;
                            rx_parity_acc_next = 1'b0;
                            rx_mode_next       = RX_DATA;
                        end
                        RX_DATA:
                        begin
                            rx_shift_next = rx_shift_reg
                                | (8'(item.data.rx_level) << rx_bit_count_reg[2:0]);
                            rx_parity_acc_next = rx_parity_acc_reg ^ item.data.rx_level;
                            rx_bit_count_next  = rx_bit_count_reg + 4'd1;
                            if (rx_bit_count_next >= 4'd8)
                            begin
                                rx_mode_next = (parity_mode_reg == PARITY_NONE)
                                               ? RX_STOP : RX_PAR;
                            end
                        end
                        RX_PAR:
                        begin
                            rx_parity_acc_next = rx_parity_acc_reg ^ item.data.rx_level;
                            rx_mode_next       = RX_STOP;
                        end
                        RX_STOP:
                        begin
                            if (parity_mode_reg == PARITY_ODD)
                            begin
                                rx_bad = !rx_parity_acc_reg;
                            end
                            else if (parity_mode_reg != PARITY_NONE)
                            begin
                                rx_bad = rx_parity_acc_reg;
                            end
                            out_word_next.rx_byte         = rx_bad ? 8'd0 : rx_shift_reg;
                            out_word_next.rx_valid        = 1'b1;
                            out_word_next.rx_parity_error = rx_bad;
                            rx_shift_next      = '0;
                            rx_bit_count_next  = '0;
                            rx_parity_acc_next = 1'b0;
                            rx_mode_next       = RX_WAIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    unique case (tx_mode_reg)
                        TX_OFF:
                        begin
                            if (tx_queue_count_reg != '0)
                            begin
                                tx_mode_next = TX_START;
                            end
                        end
                        TX_START:
                        begin
                            tx_line_next       = 1'b0;
                            tx_bit_count_next  = '0;
                            tx_parity_acc_next = 1'b0;
                            tx_mode_next       = TX_DATA;
                        end
                        TX_DATA:
                        begin
                            tx_line_next       = tx_bit;
                            tx_parity_acc_next = tx_parity_acc_reg ^ tx_bit;
                            tx_bit_count_next  = tx_bit_count_reg + 4'd1;
                            if (tx_bit_count_next >= 4'd8)
                            begin
                                tx_mode_next = (parity_mode_reg == PARITY_NONE)
                                               ? TX_STOP : TX_PAR;
                            end
                        end
                        TX_PAR:
                        begin
                            tx_line_next = (parity_mode_reg == PARITY_ODD)
                                           ? !tx_parity_acc_reg : tx_parity_acc_reg;
                            tx_mode_next = TX_STOP;
                        end
                        TX_STOP:
                        begin
                            tx_line_next = 1'b1;
                            if (tx_queue_count_reg != '0)
                            begin
                                tx_queue_count_next = tx_queue_count_reg - 1'b1;
                                tx_read_ptr_next    = (tx_read_ptr_reg == PTR_LAST)
                                                      ? '0 : tx_read_ptr_reg + 1'b1;
                            end
                            tx_mode_next = (tx_queue_count_next != '0) ? TX_START : TX_OFF;
                        end
                        default:
                        begin
                            tx_mode_next = TX_OFF;
                        end
                    endcase
                end
                if ((rx_mode_reg == RX_WAIT) && rx_prev_level_reg && !item.data.rx_level)
                begin
                    rx_mode_next = RX_IDLE;
                end
                rx_prev_level_next = item.data.rx_level;
            end
        end

        out_word_next.tx_level = tx_line_next;
        out_word_next.tx_busy  = (tx_mode_next != TX_OFF) || (tx_queue_count_next != '0);
    end

    // The head register is loaded from the next read pointer, so it holds the entry at the current one.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tx_queue_mem[tx_write_ptr_reg] <= item.data.tx_byte;
        end
        if (mem_we && (tx_write_ptr_reg == tx_read_ptr_next))
        begin
            tx_head_reg <= item.data.tx_byte;
        end
        else
        begin
            tx_head_reg <= tx_queue_mem[tx_read_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_mode_reg    <= PARITY_NONE;
            tick_phase_reg     <= 1'b0;
            rx_mode_reg        <= RX_WAIT;
            rx_shift_reg       <= '0;
            rx_bit_count_reg   <= '0;
            rx_parity_acc_reg  <= 1'b0;
            rx_prev_level_reg  <= 1'b1;
            tx_mode_reg        <= TX_OFF;
            tx_bit_count_reg   <= '0;
            tx_parity_acc_reg  <= 1'b0;
            tx_line_reg        <= 1'b1;
            tx_read_ptr_reg    <= '0;
            tx_write_ptr_reg   <= '0;
            tx_queue_count_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[APB_ADDR_W-1] == REG_IDX_PARITY_MODE))
            begin
                parity_mode_reg <= pwdata[PARITY_MODE_W-1:0];
            end
            tick_phase_reg     <= tick_phase_next;
            rx_mode_reg        <= rx_mode_next;
            rx_shift_reg       <= rx_shift_next;
            rx_bit_count_reg   <= rx_bit_count_next;
            rx_parity_acc_reg  <= rx_parity_acc_next;
            rx_prev_level_reg  <= rx_prev_level_next;
            tx_mode_reg        <= tx_mode_next;
            tx_bit_count_reg   <= tx_bit_count_next;
            tx_parity_acc_reg  <= tx_parity_acc_next;
            tx_line_reg        <= tx_line_next;
            tx_read_ptr_reg    <= tx_read_ptr_next;
            tx_write_ptr_reg   <= tx_write_ptr_next;
            tx_queue_count_reg <= tx_queue_count_next;
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        tx_queue_count_reg <= CNT_FULL)
        else $error("Transmit queue count exceeds the queue depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (tx_mode_reg != TX_OFF) |-> (tx_queue_count_reg != '0))
        else $error("Transmitter is active with an empty queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.rx_parity_error)
        |-> (out_word_reg.rx_valid && (out_word_reg.rx_byte == 8'd0)))
        else $error("Parity error word carries data or lacks its valid flag.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (item.data.action == ACT_QUEUE))
        |=> (tick_phase_reg == $past(tick_phase_reg)))
        else $error("A queue word changed the tick phase.");

endmodule
